FILE: sv/psad_pkg.sv
// Package for the block ADPCM decoder: address width, sequencer states,
// the multiply-accumulate control struct and the prediction coefficient tables.
// Depends on nothing; every other file of the block imports it.
package psad_pkg;

	localparam int ADDR_BITS = 21;
	localparam int CFG_W     = 21;
	localparam int NEXT_W    = 21;
	localparam int ACC_W     = 25;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic first;
	} mac_ctl_t;

	localparam logic [3:0] POS_HEADER = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;
	localparam logic [3:0] POS_LAST   = 4'd15;

	localparam logic [2:0] FILTER_MAX = 3'd4;

	// Coefficient applied to the newest sample. Codes above four share the last row.
	function automatic logic signed [7:0] coef_a(input logic [2:0] f);
		logic signed [7:0] c;
		case (f)
			3'd0: c = 8'sd0;
			3'd1: c = 8'sd60;
			3'd2: c = 8'sd115;
			3'd3: c = 8'sd98;
			default: c = 8'sd122;
		endcase
		return c;
	endfunction

	// Coefficient applied to the older sample.
	function automatic logic signed [7:0] coef_b(input logic [2:0] f);
		logic signed [7:0] c;
		case (f)
			3'd0: c = 8'sd0;
			3'd1: c = 8'sd0;
			3'd2: c = -8'sd52;
			3'd3: c = -8'sd55;
			default: c = -8'sd60;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/ps_adpcm_block_decoder.sv
// Top level of the block ADPCM decoder: sequencer, voice state and sample finish.
// Depends on psad_pkg and instantiates psad_mac.
//
//  channel  signals                                         direction
//  in       in_valid, in_ready, restart, byte_value         transfer into block
//  out      out_valid, out_ready, sample, last_of_item,     transfer out of block
//           block_complete, next_address, voice_stopped
//  cfg      cfg_we, cfg_wdata (start_address)               write, no handshake
//
// A header or flags byte, or a byte dropped by a stopped voice, is taken in the idle state.
// A data byte is taken in the idle state; each of its nibbles then passes through
// ST_MUL_A and ST_MUL_B on the shared multiply-accumulate unit (two products), then
// ST_FINISH (round, add and clamp) and ST_OUT, which holds the sample until taken.
// in_ready is high only in the idle state; an output stall holds the sequencer.
// Reset is asynchronous and leaves the voice stopped until a restart.
module ps_adpcm_block_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psad_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        restart,
	input  logic [7:0]                  byte_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          sample,
	output logic                        last_of_item,
	output logic                        block_complete,
	output logic [psad_pkg::NEXT_W-1:0] next_address,
	output logic                        voice_stopped
);
	import psad_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0] start_q;
	logic [3:0]       pos_q;
	logic [3:0]       shift_q;
	logic [2:0]       filter_q;
	logic             end_flag_q;
	logic signed [15:0] newest_q, older_q;
	addr_t            block_addr_q, loop_addr_q;
	logic             looping_q, stopped_q;
	logic [7:0]       byte_q;
	logic             nib_sel_q;
	logic             last_byte_q;

	logic signed [15:0] sample_q;
	logic             last_q, complete_q, halt_q;
	logic [NEXT_W-1:0] next_q;

	logic             stop_eff;
	logic [3:0]       pos_eff;
	logic             in_xfer, out_xfer;
	mac_ctl_t         mac_ctl;
	logic signed [15:0] mac_operand;
	logic signed [7:0]  mac_coef;
	logic signed [ACC_W-1:0] acc;

	logic [3:0]              nibble;
	logic signed [15:0]      base;
	logic signed [ACC_W-1:0] rounded, pred, total;
	logic signed [15:0]      clamped;
	addr_t                   seq_addr, next_addr;
	logic                    halt;
	logic [2:0]              filter_in;

	assign stop_eff = restart ? 1'b0 : stopped_q;
	assign pos_eff  = restart ? POS_HEADER : pos_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Sample finish: scaled nibble plus rounded prediction, clamped to 16 bits.
	assign nibble  = nib_sel_q ? byte_q[7:4] : byte_q[3:0];
	assign base    = $signed({nibble, 12'b0}) >>> shift_q;
	assign rounded = acc + ACC_W'(32);
	assign pred    = rounded >>> 6;
	assign total   = ACC_W'(base) + pred;

	always_comb begin
		if (total > ACC_W'(32767)) begin
			clamped = 16'sh7FFF;
		end else if (total < -ACC_W'(32768)) begin
			clamped = -16'sh8000;
		end else begin
			clamped = total[15:0];
		end
	end

	// End of block: advance, loop back, or stop.
	assign seq_addr  = block_addr_q + addr_t'(16);
	assign halt      = end_flag_q && !looping_q;
	assign next_addr = (end_flag_q && looping_q) ? loop_addr_q : seq_addr;
	assign filter_in = (byte_value[6:4] > FILTER_MAX) ? FILTER_MAX : byte_value[6:4];

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		mac_ctl     = '{en: 1'b0, first: 1'b0};
		mac_operand = newest_q;
		mac_coef    = coef_a(filter_q);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !stop_eff && pos_eff != POS_HEADER && pos_eff != POS_FLAGS) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				mac_ctl = '{en: 1'b1, first: 1'b1};
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				mac_ctl     = '{en: 1'b1, first: 1'b0};
				mac_operand = older_q;
				mac_coef    = coef_b(filter_q);
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = nib_sel_q ? ST_IDLE : ST_MUL_A;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			pos_q        <= '0;
			shift_q      <= '0;
			filter_q     <= '0;
			end_flag_q   <= 1'b0;
			newest_q     <= '0;
			older_q      <= '0;
			block_addr_q <= '0;
			loop_addr_q  <= '0;
			looping_q    <= 1'b0;
			stopped_q    <= 1'b1;
			nib_sel_q    <= 1'b0;
			last_byte_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (in_xfer) begin
				if (restart) begin
					block_addr_q <= addr_t'(start_q);
					newest_q     <= '0;
					older_q      <= '0;
					looping_q    <= 1'b0;
					end_flag_q   <= 1'b0;
					stopped_q    <= 1'b0;
				end
				if (!stop_eff) begin
					pos_q <= pos_eff + 4'd1;
					if (pos_eff == POS_HEADER) begin
						shift_q  <= byte_value[3:0];
						filter_q <= filter_in;
					end else if (pos_eff == POS_FLAGS) begin
						end_flag_q <= byte_value[0];
						if (byte_value[2]) begin
							loop_addr_q <= block_addr_q;
							looping_q   <= 1'b1;
						end
					end else begin
						nib_sel_q   <= 1'b0;
						last_byte_q <= (pos_eff == POS_LAST);
					end
				end
			end
			if (state_q == ST_FINISH) begin
				older_q  <= newest_q;
				newest_q <= clamped;
				if (nib_sel_q && last_byte_q) begin
					block_addr_q <= next_addr;
					if (halt) begin
						stopped_q <= 1'b1;
					end
				end
			end
			if (state_q == ST_OUT && out_xfer && !nib_sel_q) begin
				nib_sel_q <= 1'b1;
			end
		end
	end

	// Output register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			sample_q   <= clamped;
			last_q     <= nib_sel_q;
			complete_q <= nib_sel_q && last_byte_q;
			if (nib_sel_q && last_byte_q) begin
				next_q <= NEXT_W'(next_addr);
				halt_q <= halt;
			end else begin
				next_q <= '0;
				halt_q <= 1'b0;
			end
		end
		if (in_xfer && !stop_eff && pos_eff != POS_HEADER && pos_eff != POS_FLAGS) begin
			byte_q <= byte_value;
		end
	end

	psad_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.operand (mac_operand),
		.coef    (mac_coef),
		.acc     (acc)
	);

	assign sample         = sample_q;
	assign last_of_item   = last_q;
	assign block_complete = complete_q;
	assign next_address   = next_q;
	assign voice_stopped  = halt_q;

endmodule

FILE: sv/psad_mac.sv
// Shared multiply-accumulate unit for the two-tap prediction.
// Depends on psad_pkg for the accumulator width and the control struct.
// One 16x8 signed product per cycle while ctl.en is high, loaded or added into the accumulator.
module psad_mac (
	input  logic                             clk,
	input  psad_pkg::mac_ctl_t               ctl,
	input  logic signed [15:0]               operand,
	input  logic signed [7:0]                coef,
	output logic signed [psad_pkg::ACC_W-1:0] acc
);
	import psad_pkg::*;

	logic signed [23:0]      prod;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_q;

	assign prod     = operand * coef;
	assign prod_ext = ACC_W'(prod);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.first) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	assign acc = acc_q;

endmodule

FILE: tb/psad_tb_pkg.sv
// Result type and checker class for the block ADPCM decoder testbench.
// The checker predicts decoded samples from the accepted bytes and compares them.
// Depends on psad_pkg for the address type, block positions and filter limit.
package psad_tb_pkg;

	import psad_pkg::*;

	typedef struct packed {
		logic signed [15:0]  sample;
		logic                last;
		logic                complete;
		logic [NEXT_W-1:0]   next_addr;
		logic                halted;
	} pcm_word_t;

	class decoded_sample_checker;

		addr_t              cfg_start;
		logic [3:0]         pos_cnt;
		logic [3:0]         shift_r;
		logic [2:0]         filt_r;
		bit                 end_seen;
		bit                 loop_armed;
		bit                 halted;
		logic signed [15:0] hist1;
		logic signed [15:0] hist2;
		addr_t              base_addr;
		addr_t              loop_base;
		int                 coef_new[5];
		int                 coef_old[5];
		pcm_word_t          expected_samples[$];
		int                 mismatches;

		function new();
			cfg_start  = '0;
			pos_cnt    = '0;
			shift_r    = '0;
			filt_r     = '0;
			end_seen   = 1'b0;
			loop_armed = 1'b0;
			halted     = 1'b1;
			hist1      = '0;
			hist2      = '0;
			base_addr  = '0;
			loop_base  = '0;
			coef_new   = '{0, 60, 115, 98, 122};
			coef_old   = '{0, 0, -52, -55, -60};
			mismatches = 0;
		endfunction

		function void set_start(addr_t a);
			cfg_start = a;
		endfunction

		function bit is_halted();
			return halted;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		function logic signed [15:0] predict_nibble(logic [3:0] nib);
			int v;
			int acc;
			v = int'($signed(nib)) * 4096;
			v = v >>> shift_r;
			acc = int'(hist1) * coef_new[filt_r] + int'(hist2) * coef_old[filt_r] + 32;
			v += acc >>> 6;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			hist2 = hist1;
			hist1 = v[15:0];
			return hist1;
		endfunction

		// Returns 1 when the byte was consumed, 0 when a stopped voice dropped it.
		function bit take_byte(bit rst, logic [7:0] b);
			logic [3:0] p;
			pcm_word_t  w[2];
			addr_t      nxt;
			bit         halt_now;
			if (rst) begin
				base_addr  = cfg_start;
				hist1      = '0;
				hist2      = '0;
				loop_armed = 1'b0;
				end_seen   = 1'b0;
				halted     = 1'b0;
				pos_cnt    = POS_HEADER;
			end
			if (halted)
				return 1'b0;
			p = pos_cnt;
			pos_cnt = pos_cnt + 4'd1;
			if (p == POS_HEADER) begin
				shift_r = b[3:0];
				filt_r  = (b[6:4] > FILTER_MAX) ? FILTER_MAX : b[6:4];
				return 1'b1;
			end
			if (p == POS_FLAGS) begin
				end_seen = b[0];
				if (b[2]) begin
					loop_base  = base_addr;
					loop_armed = 1'b1;
				end
				return 1'b1;
			end
			for (int k = 0; k < 2; k++) begin
				w[k] = '0;
				w[k].sample = predict_nibble(k == 0 ? b[3:0] : b[7:4]);
				w[k].last = (k == 1);
			end
			if (p == POS_LAST) begin
				nxt = base_addr + addr_t'(16);
				halt_now = 1'b0;
				if (end_seen) begin
					if (loop_armed)
						nxt = loop_base;
					else
						halt_now = 1'b1;
				end
				base_addr = nxt;
				halted = halt_now;
				w[1].complete  = 1'b1;
				w[1].next_addr = nxt[NEXT_W-1:0];
				w[1].halted    = halt_now;
			end
			expected_samples.push_back(w[0]);
			expected_samples.push_back(w[1]);
			return 1'b1;
		endfunction

		function void report(string what, pcm_word_t e, pcm_word_t g);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: sample %0d/%0d last %0b/%0b complete %0b/%0b next %h/%h stop %0b/%0b",
					what, e.sample, g.sample, e.last, g.last, e.complete, g.complete,
					e.next_addr, g.next_addr, e.halted, g.halted);
		endfunction

		function void check_sample(pcm_word_t got);
			pcm_word_t exp_w;
			if (expected_samples.size() == 0) begin
				report("unexpected sample (exp/got)", '0, got);
				return;
			end
			exp_w = expected_samples.pop_front();
			if (got.sample !== exp_w.sample || got.last !== exp_w.last ||
			    got.complete !== exp_w.complete || got.next_addr !== exp_w.next_addr ||
			    got.halted !== exp_w.halted)
				report("sample mismatch (exp/got)", exp_w, got);
		endfunction

		function void flush_leftovers();
			while (expected_samples.size() > 0)
				report("sample never delivered (exp/got)", expected_samples.pop_front(), '0);
		endfunction

	endclass

endpackage

FILE: tb/tb_ps_adpcm_block_decoder.sv
// Testbench top for ps_adpcm_block_decoder: drives byte streams of 16-byte blocks,
// varies start addresses and handshake pressure, and checks every sample transfer.
// Depends on psad_pkg and psad_tb_pkg.
module tb_ps_adpcm_block_decoder;

	import psad_pkg::*;
	import psad_tb_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_LEN     = 300;
	localparam int SETTLE       = 30;
	localparam int PHASE_ITEMS  = 330;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              restart = 1'b0;
	logic [7:0]        byte_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [15:0] sample;
	logic              last_of_item;
	logic              block_complete;
	logic [NEXT_W-1:0] next_address;
	logic              voice_stopped;

	decoded_sample_checker sb = new();

	int cycle_cnt = 0;
	int used_items = 0;
	int in_idle_pct = 0;
	int stall_pct = 0;
	int hold_req_id = 0;
	int hold_seen = 0;
	int hold_left = 0;

	ps_adpcm_block_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.restart        (restart),
		.byte_value     (byte_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.last_of_item   (last_of_item),
		.block_complete (block_complete),
		.next_address   (next_address),
		.voice_stopped  (voice_stopped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("ps_adpcm_block_decoder regression: fail");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever the stimulus requests one.
	always @(negedge clk) begin
		if (hold_req_id != hold_seen) begin
			hold_seen = hold_req_id;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pcm_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.sample    = sample;
			got.last      = last_of_item;
			got.complete  = block_complete;
			got.next_addr = next_address;
			got.halted    = voice_stopped;
			sb.check_sample(got);
		end
	end

	// Entered and left at a falling edge; valid stays high unless a gap follows.
	task automatic send_byte(bit rst, logic [7:0] b);
		int gap;
		gap = 0;
		while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		restart    <= rst;
		byte_value <= b;
		do
			@(posedge clk);
		while (!in_ready);
		if (sb.take_byte(rst, b))
			used_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// Header bytes give no samples, so let the block settle before reconfiguring.
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic begin_phase(int idle, int stall, addr_t start);
		drain();
		in_idle_pct = idle;
		stall_pct   = stall;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= start;
		sb.set_start(start);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] data_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: b = 8'h77;
				1: b = 8'h88;
				2: b = 8'h7F;
				default: b = 8'h80;
			endcase
		end
		return b;
	endfunction

	function automatic logic [7:0] flags_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		b[0] = ($urandom_range(99) < 30);
		b[2] = ($urandom_range(99) < 45);
		return b;
	endfunction

	// A well-formed playback: restart on the first header, then whole blocks until the
	// voice stops or the block count runs out.
	task automatic play_voice();
		int nblk;
		nblk = $urandom_range(1, 6);
		for (int blk = 0; blk < nblk; blk++) begin
			send_byte(blk == 0, 8'($urandom_range(255)));
			send_byte(1'b0, flags_byte());
			for (int i = 2; i < 16; i++)
				send_byte(1'b0, data_byte());
			if (sb.is_halted())
				break;
		end
	endtask

	// Noise: random bytes with occasional restarts, cutting blocks short.
	task automatic play_noise();
		int len;
		len = $urandom_range(1, 20);
		repeat (len)
			send_byte($urandom_range(99) < 15, 8'($urandom_range(255)));
	endtask

	task automatic run_random(int target);
		while (used_items < target) begin
			if ($urandom_range(99) < 85)
				play_voice();
			else
				play_noise();
		end
	endtask

	initial begin
		logic [7:0] seq_a[14];
		int target;
		seq_a = '{8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h08,
		          8'h80, 8'hF0, 8'h0F, 8'h00, 8'hFF, 8'h7F, 8'h81};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A voice is stopped out of reset, so these bytes must be dropped.
		send_byte(1'b0, 8'h5A);
		send_byte(1'b0, 8'hA5);
		begin_phase(0, 0, addr_t'(21'h1FFFF0));
		// Filter code seven with shift zero drives the prediction into both clamps;
		// the flags byte sets loop end and loop start together with the unused bits but bit 1.
		send_byte(1'b1, 8'h70);
		send_byte(1'b0, 8'hFD);
		foreach (seq_a[i])
			send_byte(1'b0, seq_a[i]);

		target = used_items + PHASE_ITEMS;
		run_random(target);
		begin_phase(49, 0, addr_t'(0));
		target = used_items + PHASE_ITEMS;
		run_random(target);
		begin_phase(0, 49, addr_t'(21'h1FFFFF));
		target = used_items + PHASE_ITEMS;
		run_random(target);
		begin_phase(9, 9, addr_t'($urandom_range(21'h1FFFFF)));
		target = used_items + PHASE_ITEMS;
		run_random(target);

		// Hold the receiver off while bytes keep coming so the block backs up.
		begin_phase(0, 0, addr_t'(21'h1FFFF0 | $urandom_range(15)));
		@(posedge clk);
		hold_req_id++;
		@(negedge clk);
		target = used_items + PHASE_ITEMS;
		run_random(target);

		drain();
		sb.flush_leftovers();
		if (sb.mismatches == 0)
			$display("ps_adpcm_block_decoder regression: pass");
		else
			$display("ps_adpcm_block_decoder regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
sv/psad_pkg.sv
sv/psad_mac.sv
sv/ps_adpcm_block_decoder.sv
tb/psad_tb_pkg.sv
tb/tb_ps_adpcm_block_decoder.sv
